// ----- hw/rtl/band_flux_onset_detector_defines.svh -----
// Assertion macros for the band flux onset detector
`ifndef BAND_FLUX_ONSET_DETECTOR_DEFINES_SVH
`define BAND_FLUX_ONSET_DETECTOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define BFOD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define BFOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/bfod_pkg.sv -----
// ----------------------------------------------------------------------------
// bfod_pkg
// Shared constants, types and elaboration helpers of the onset detector.
// ----------------------------------------------------------------------------
package bfod_pkg;

  localparam int NUM_BANDS_DEF      = 64;
  localparam int CONTEXT_FRAMES_DEF = 2;

  localparam int ENERGY_W = 16;
  localparam int RATIO_W  = 16;
  localparam int THR_W    = 16;
  localparam int SIL_W    = 22;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 22;
  localparam int FRAMES_W = 5;
  localparam int FLUX_W   = 40;
  localparam int ESUM_W   = 24;
  localparam int QUO_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE   = 1'b1;

  localparam logic [FRAMES_W-1:0] FRAMES_MAX = 5'd31;
  localparam logic [RATIO_W-1:0]  RATIO_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [RATIO_W-1:0] onset_strength;
    logic               last_of_run;
  } result_t;

  // lcm(1..c) for the supported context range
  function automatic int weight_scale_f(input int c);
    int l;
    unique case (c)
      0, 1:    l = 1;
      2:       l = 2;
      3:       l = 6;
      4:       l = 12;
      5, 6:    l = 60;
      7:       l = 420;
      default: l = 840;
    endcase
    return l;
  endfunction

  function automatic int ratio_div_f(input int c);
    int sq;
    sq = 0;
    for (int i = 1; i <= 8; i++) begin
      if (i <= c) sq = sq + i * i;
    end
    return (c == 0) ? 1 : weight_scale_f(c) * 2 * sq;
  endfunction

  function automatic int clog2_f(input int v);
    int r;
    r = 0;
    for (int k = 0; k < 31; k++) begin
      if ((1 << r) < v) r = r + 1;
    end
    return (r == 0) ? 1 : r;
  endfunction

endpackage

// ----- hw/rtl/bfod_stream_if.sv -----
// ----------------------------------------------------------------------------
// bfod_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface bfod_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bfod_ram.sv -----
// ----------------------------------------------------------------------------
// bfod_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bfod_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/bfod_divider.sv -----
// ----------------------------------------------------------------------------
// bfod_divider
// Radix-2 restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module bfod_divider
  import bfod_pkg::*;
#(
  parameter int NUM_W = 56,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [RATIO_W-1:0] quo
);
  localparam int CNT_W = clog2_f(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign diff  = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        rem  <= '0;
        d    <= den;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        if (!diff[DEN_W]) begin
          rem <= diff;
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits above the ratio width force saturation
  always_comb begin
    if (q[NUM_W-1:RATIO_W] != '0) quo = RATIO_MAX;
    else quo = q[RATIO_W-1:0];
  end
endmodule

// ----- hw/rtl/band_flux_onset_detector.sv -----
// ----------------------------------------------------------------------------
// band_flux_onset_detector
// Relative spectral flux onset detection over per-band energy history.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one band energy (Q8.8) per item, with last_band / last_frame.
//   out_ch : onset_strength (Q4.12) per frame, last_of_run on the final one.
//   cfg    : cfg_we/cfg_idx/cfg_data; 0 = onset_threshold, 1 = silence_level.
// Throughput: one item at a time. From accept to accept, a band that does not
//   close its frame passes the accept, reads of its HD history entries through
//   the single registered RAM read port, then HD history writes; HD =
//   2 * CONTEXT_FRAMES - 1 (1 for no context), 3 at the default.
// A closing band adds a step to test the frame; a frame whose ratio counts
//   runs the divider, one quotient bit per cycle.
//   Emitting takes a setup step, a valid/ready handshake per result item and
//   a step of frame bookkeeping before in_ch.ready rises again.
// The first result item of a close shows valid once the emit setup step has
//   computed the outputs; in_ch.ready stays low until every result is taken.
// Reset: clears stream state and registers; history RAM is not cleared, its
//   unwritten entries must not feed a frame whose ratio counts.
// Stall: the block holds the result and waits while out_ch.ready is low.
// ----------------------------------------------------------------------------
module band_flux_onset_detector
  import bfod_pkg::*;
#(
  parameter int NUM_BANDS      = NUM_BANDS_DEF,
  parameter int CONTEXT_FRAMES = CONTEXT_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  bfod_stream_if.sink          in_ch,
  bfod_stream_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);
  localparam int C     = CONTEXT_FRAMES;
  localparam int HD    = (C > 0) ? 2 * C - 1 : 1;
  localparam int LAG   = (C > 0) ? C - 1 : 0;
  localparam int SD    = (LAG > 0) ? LAG : 1;
  localparam int BW    = clog2_f(NUM_BANDS);
  localparam int HW    = clog2_f(HD);
  localparam int DEPTH = NUM_BANDS * HD;
  localparam int AW    = clog2_f(DEPTH);
  localparam int LSC   = weight_scale_f(C);
  localparam int RDIV  = ratio_div_f(C);
  localparam int NUM_W = FLUX_W + 12;
  localparam int DEN_W = ESUM_W + clog2_f(RDIV + 1);
  localparam int NRD   = (C > 0) ? HD : 1;
  localparam int RDW   = clog2_f(NRD + 1);
  localparam int DTW   = 48;
  localparam int OCW   = 4;
  localparam int WT1   = LSC / 1;
  localparam int WT2   = LSC / 2;
  localparam int WT3   = LSC / 3;
  localparam int WT4   = LSC / 4;
  localparam int WT5   = LSC / 5;
  localparam int WT6   = LSC / 6;
  localparam int WT7   = LSC / 7;
  localparam int WT8   = LSC / 8;

  // payload of the input channel assumed {band_energy, last_band, last_frame}
  logic [ENERGY_W-1:0] band_energy;
  logic                last_band;
  logic                last_frame;
  assign {band_energy, last_band, last_frame} = in_ch.data;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WRITE, S_CLOSE, S_DIV, S_EMIT
  } state_t;

  state_t state;
  logic [THR_W-1:0] onset_threshold;
  logic [SIL_W-1:0] silence_level;

  logic [BW-1:0]  band_position;
  logic [FRAMES_W-1:0] frames_seen;
  logic [FLUX_W-1:0] flux_acc;
  logic [ESUM_W-1:0] energy_acc;
  logic [ESUM_W-1:0] dsum [SD];
  logic [RATIO_W-1:0] r_old, r_new;
  logic [ENERGY_W-1:0] x;
  logic lb, lf;
  logic [BW-1:0] b;
  logic [RDW-1:0] rcnt;
  logic [HW-1:0] hk;
  logic [ENERGY_W-1:0] hist [NRD];
  logic signed [DTW-1:0] dacc;
  logic [RATIO_W-1:0] cur;
  logic [OCW-1:0] n_out, emit_k;
  logic [RATIO_W-1:0] first_val;
  logic has_peak_slot;

  // RAM
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ENERGY_W-1:0] wdata, rdata;
  bfod_ram #(.WIDTH(ENERGY_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // divider
  logic div_start, div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [RATIO_W-1:0] div_quo;
  bfod_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  logic [ESUM_W-1:0] e_sel;
  assign e_sel = (LAG > 0) ? dsum[SD-1] : energy_acc;

  // history value "back" frames before current (back 0 = x)
  function automatic logic signed [DTW-1:0] pv(input int back);
    logic signed [DTW-1:0] r;
    r = '0;
    if (back == 0) r = DTW'(x);
    else if (back <= NRD) r = DTW'(hist[HW'(back - 1)]);
    return r;
  endfunction

  // regression weight lcm / i
  function automatic int wt_f(input int i);
    int w;
    unique case (i)
      1:       w = WT1;
      2:       w = WT2;
      3:       w = WT3;
      4:       w = WT4;
      5:       w = WT5;
      6:       w = WT6;
      7:       w = WT7;
      default: w = WT8;
    endcase
    return w;
  endfunction

  // band derivative: C is small, at most 8 narrow terms
  always_comb begin
    dacc = '0;
    if (C == 0) begin
      dacc = (frames_seen == '0) ? pv(0) : pv(0) - pv(1);
    end else begin
      for (int i = 1; i <= 8; i++) begin
        if (i <= C) dacc = dacc + DTW'(wt_f(i)) * (pv(C - i) - pv(C - 1 + i));
      end
    end
  end

  logic closes;
  assign closes = lb || (b == BW'(NUM_BANDS - 1));

  logic valid_ratio;
  assign valid_ratio = (C == 0) ||
                       ((32'(frames_seen) >= 32'(2 * C - 1)) && !lf);

  logic emits_peak;
  assign emits_peak = 32'(frames_seen) >= 32'(LAG + 1);

  assign div_num = {flux_acc, 12'b0};
  assign div_den = DEN_W'(RDIV) * DEN_W'(e_sel);

  assign in_ch.ready = (state == S_IDLE);
  assign raddr = AW'(32'(b) * HD + 32'(rcnt));

  always_comb begin
    we    = 1'b0;
    waddr = AW'(32'(b) * HD + 32'(hk));
    wdata = (hk == '0) ? x : hist[hk - 1'b1];
    if (state == S_WRITE) we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      onset_threshold <= '0;
      silence_level <= '0;
      band_position <= '0;
      frames_seen <= '0;
      flux_acc <= '0;
      energy_acc <= '0;
      for (int k = 0; k < SD; k++) dsum[k] <= '0;
      r_old <= '0;
      r_new <= '0;
      out_ch.valid <= 1'b0;
      div_start <= 1'b0;
      rcnt <= '0;
      hk <= '0;
      n_out <= '0;
      emit_k <= '0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_THRESHOLD: onset_threshold <= cfg_data[THR_W-1:0];
          REG_SILENCE:   silence_level <= cfg_data[SIL_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            x  <= band_energy;
            lb <= last_band;
            lf <= last_frame;
            b  <= band_position;
            rcnt <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          // read data of address rcnt-1 lands now
          if (rcnt != '0) hist[HW'(rcnt - 1'b1)] <= rdata;
          if (32'(rcnt) == NRD) begin
            hk <= HW'(HD - 1);
            state <= S_WRITE;
          end
          rcnt <= rcnt + 1'b1;
        end
        S_WRITE: begin
          if (hk == '0) begin
            if (dacc > 0) flux_acc <= flux_acc + FLUX_W'(dacc);
            energy_acc <= energy_acc + ESUM_W'(x);
            if (!closes) begin
              band_position <= b + 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_CLOSE;
            end
          end
          hk <= hk - 1'b1;
        end
        S_CLOSE: begin
          if (32'(frames_seen) >= LAG && valid_ratio && (e_sel > ESUM_W'(silence_level))) begin
            div_start <= 1'b1;
            state <= S_DIV;
          end else begin
            cur <= '0;
            state <= S_EMIT;
            emit_k <= '0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cur <= div_quo;
            state <= S_EMIT;
            emit_k <= '0;
          end
        end
        S_EMIT: begin
          if (!out_ch.valid && emit_k == '0) begin
            // compute outputs of this close
            has_peak_slot <= (32'(frames_seen) >= LAG) && emits_peak;
            first_val <= ((32'(frames_seen) != LAG + 1) && r_new > r_old &&
                          r_new > cur && r_new >= onset_threshold) ? r_new : '0;
            n_out <= OCW'(((32'(frames_seen) >= LAG) && emits_peak ? 1 : 0) +
                     (lf ? ((32'(frames_seen) >= LAG) ? LAG + 1
                                                      : 32'(frames_seen) + 1) : 0));
            if (32'(frames_seen) >= LAG) begin
              r_old <= r_new;
              r_new <= cur;
            end
            emit_k <= OCW'(1);
          end else if (!out_ch.valid) begin
            if (emit_k > n_out) begin
              // frame bookkeeping
              if (lf) begin
                band_position <= '0;
                frames_seen <= '0;
                flux_acc <= '0;
                energy_acc <= '0;
                for (int k = 0; k < SD; k++) dsum[k] <= '0;
                r_old <= '0;
                r_new <= '0;
              end else begin
                for (int k = SD - 1; k > 0; k--) dsum[k] <= dsum[k-1];
                dsum[0] <= energy_acc;
                if (frames_seen != FRAMES_MAX) frames_seen <= frames_seen + 1'b1;
                flux_acc <= '0;
                energy_acc <= '0;
                band_position <= '0;
              end
              state <= S_IDLE;
            end else begin
              out_ch.data.onset_strength <= (emit_k == 1 && has_peak_slot) ? first_val : '0;
              out_ch.data.last_of_run <= (emit_k == n_out);
              out_ch.valid <= 1'b1;
            end
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            emit_k <= emit_k + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/bfod_checker.sv -----
// ----------------------------------------------------------------------------
// bfod_checker
// Port-level checks of the onset detector channels.
// ----------------------------------------------------------------------------
`include "band_flux_onset_detector_defines.svh"
module bfod_sva (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  `BFOD_ASSERT_IMPL(no_overlap, clk, rst, out_valid, !in_ready)
  `BFOD_ASSERT_NEXT(busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `BFOD_ASSERT_NEXT(out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `BFOD_ASSERT_NEXT(last_hold, clk, rst, out_valid && !out_ready, $stable(out_last))
endmodule

bind band_flux_onset_detector bfod_sva u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last_of_run)
);
